/* rtl/iprt_pkg.sv */
// Package: shared types, codes and sizes of the IPv4 fragment reassembly table.
package iprt_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW  = $clog2(TableDepth);
  localparam int unsigned CntW  = $clog2(TableDepth + 1);
  localparam int unsigned PassW = $clog2(TableDepth + 2);
  localparam logic [7:0]  LifetimeReset = 8'd30;

  typedef enum logic [1:0] {
    OpAdd     = 2'd0,
    OpCheck   = 2'd1,
    OpExtract = 2'd2,
    OpNone    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StAdded      = 3'd0,
    StFull       = 3'd1,
    StComplete   = 3'd2,
    StIncomplete = 3'd3,
    StFrag       = 3'd4,
    StBroken     = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] ident;
    logic [12:0] offset_units;
    logic        more_flag;
    logic [15:0] total_length;
    logic [3:0]  header_words;
    logic [7:0]  buffer_handle;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] ident_out;
    logic [15:0] byte_offset;
    logic [15:0] payload_len;
    logic [7:0]  handle_out;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] ident;
    logic [12:0] offset_units;
    logic [15:0] payload_len;
    logic        more;
    logic [31:0] expire;
    logic [7:0]  handle;
  } entry_t;

  // Table commands from the sequencer
  typedef struct packed {
    logic            append;
    logic            remove;
    logic [IdxW-1:0] idx;
  } tbl_cmd_t;

  // Compare unit results
  typedef struct packed {
    logic chain_hit;
    logic expired;
  } match_t;

endpackage

/* rtl/iprt_table.sv */
// Descriptor storage in insertion order, with append and shift-down removal.
module iprt_table import iprt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tbl_cmd_t        cmd_i,
  input  entry_t          wr_entry_i,
  output entry_t          rd_entry_o,
  output logic [CntW-1:0] count_o
);

  entry_t          mem_q [TableDepth];
  logic [CntW-1:0] count_q;

  assign rd_entry_o = mem_q[cmd_i.idx];
  assign count_o    = count_q;

  // Entry storage: append at the fill point, or close the gap on removal
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem_q[count_q[IdxW-1:0]] <= wr_entry_i;
    end else if (cmd_i.remove) begin
      for (int j = 0; j < TableDepth - 1; j++) begin
        if (IdxW'(j) >= cmd_i.idx) begin
          mem_q[j] <= mem_q[j+1];
        end
      end
    end
  end

  // Fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.append) begin
      count_q <= count_q + CntW'(1);
    end else if (cmd_i.remove) begin
      count_q <= count_q - CntW'(1);
    end
  end

endmodule

/* rtl/iprt_match.sv */
// Shared compare unit: chain match and expiry test for the entry under scan.
module iprt_match import iprt_pkg::*; (
  input  entry_t      entry_i,
  input  logic [15:0] ident_i,
  input  logic [15:0] off_i,
  input  logic [31:0] now_i,
  output match_t      match_o
);

  logic [15:0] start;

  assign start             = {entry_i.offset_units, 3'b000};
  assign match_o.chain_hit = (entry_i.ident == ident_i) && (start == off_i);
  assign match_o.expired   = (entry_i.expire <= now_i);

endmodule

/* rtl/ipv4_fragment_reassembly_table.sv */
// Top level: sequencer, result register and config register of the fragment table.
//
//  channel | signals                          | direction
//  in      | in_valid_i, in_ready_o, in_data_i   | item in (valid/ready)
//  out     | out_valid_o, out_ready_i, out_data_o | result out (valid/ready)
//  cfg     | cfg_we_i, cfg_wdata_i             | lifetime_seconds write
//
// One compare unit visits one table entry per cycle; a result step waits
// while the output register is full. An add sweeps expired entries if its
// time is past the last sweep, then appends; a check makes up to TableDepth
// passes, an extract up to TableDepth+1. in_ready_o is high only while idle.
// Reset empties the table and sets lifetime to 30 seconds.
module ipv4_fragment_reassembly_table import iprt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  typedef enum logic [1:0] {SIdle, SSweep, SAdd, SScan} state_e;

  state_e          state_q, state_d;
  in_item_t        item_q, item_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [PassW-1:0] pass_q, pass_d;
  logic [15:0]     off_q, off_d;
  logic            found_q, found_d;
  logic [31:0]     sweep_q, sweep_d;
  logic [7:0]      life_q;
  logic            ovalid_q, ovalid_d;
  out_item_t       odata_q, odata_d;

  tbl_cmd_t        cmd;
  entry_t          wr_entry, rd_entry;
  logic [CntW-1:0] count;
  match_t          match;
  logic            slot_free, at_end, accept;
  logic [PassW-1:0] pass_next, pass_limit;

  iprt_table u_table (
    .clk_i, .rst_ni, .cmd_i(cmd), .wr_entry_i(wr_entry),
    .rd_entry_o(rd_entry), .count_o(count)
  );

  iprt_match u_match (
    .entry_i(rd_entry), .ident_i(item_q.ident), .off_i(off_q),
    .now_i(item_q.now_seconds), .match_o(match)
  );

  assign in_ready_o  = (state_q == SIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;
  assign slot_free   = !ovalid_q || out_ready_i;
  assign at_end      = (idx_q >= count);
  assign pass_next   = pass_q + PassW'(1);
  assign pass_limit  = (item_q.opcode == OpExtract) ? PassW'(TableDepth + 1)
                                                    : PassW'(TableDepth);

  // New descriptor built from the held add item
  always_comb begin
    wr_entry.ident        = item_q.ident;
    wr_entry.offset_units = item_q.offset_units;
    wr_entry.more         = item_q.more_flag;
    wr_entry.payload_len  = item_q.total_length - {10'd0, item_q.header_words, 2'b00};
    wr_entry.expire       = item_q.now_seconds + {24'd0, life_q};
    wr_entry.handle       = item_q.buffer_handle;
  end

  // Sequencer next state
  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    idx_d    = idx_q;
    pass_d   = pass_q;
    off_d    = off_q;
    found_d  = found_q;
    sweep_d  = sweep_q;
    ovalid_d = ovalid_q && !out_ready_i;
    odata_d  = odata_q;
    cmd      = '{append: 1'b0, remove: 1'b0, idx: idx_q[IdxW-1:0]};

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          item_d  = in_data_i;
          idx_d   = '0;
          pass_d  = '0;
          off_d   = '0;
          found_d = 1'b0;
          case (in_data_i.opcode) inside
            OpAdd: begin
              if (in_data_i.now_seconds > sweep_q) begin
                sweep_d = in_data_i.now_seconds;
                state_d = SSweep;
              end else begin
                state_d = SAdd;
              end
            end
            OpCheck, OpExtract: state_d = SScan;
            default: state_d = SIdle;
          endcase
        end
      end
      SSweep: begin
        if (at_end) begin
          state_d = SAdd;
        end else if (match.expired) begin
          cmd.remove = 1'b1;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
      SAdd: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          odata_d  = '0;
          odata_d.last = 1'b1;
          if (count >= CntW'(TableDepth)) begin
            odata_d.status = StFull;
          end else begin
            cmd.append        = 1'b1;
            odata_d.status    = StAdded;
            odata_d.ident_out = item_q.ident;
          end
          state_d = SIdle;
        end
      end
      SScan: begin
        if (slot_free) begin
          if (at_end) begin
            // End of one pass over the table
            if (found_q && pass_next < pass_limit) begin
              pass_d  = pass_next;
              found_d = 1'b0;
              idx_d   = '0;
            end else begin
              ovalid_d = 1'b1;
              odata_d  = '0;
              odata_d.last   = 1'b1;
              odata_d.status = (item_q.opcode == OpExtract) ? StBroken : StIncomplete;
              state_d  = SIdle;
            end
          end else if (match.chain_hit) begin
            found_d = 1'b1;
            off_d   = off_q + rd_entry.payload_len;
            if (item_q.opcode == OpExtract) begin
              cmd.remove = 1'b1;
              ovalid_d   = 1'b1;
              odata_d.status      = StFrag;
              odata_d.ident_out   = '0;
              odata_d.byte_offset = off_q;
              odata_d.payload_len = rd_entry.payload_len;
              odata_d.handle_out  = rd_entry.handle;
              odata_d.last        = !rd_entry.more;
              if (!rd_entry.more) state_d = SIdle;
            end else begin
              idx_d = idx_q + CntW'(1);
              if (!rd_entry.more) begin
                ovalid_d = 1'b1;
                odata_d  = '0;
                odata_d.last   = 1'b1;
                odata_d.status = StComplete;
                state_d  = SIdle;
              end
            end
          end else begin
            idx_d = idx_q + CntW'(1);
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      idx_q    <= '0;
      pass_q   <= '0;
      found_q  <= 1'b0;
      sweep_q  <= '0;
      life_q   <= LifetimeReset;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      pass_q   <= pass_d;
      found_q  <= found_d;
      sweep_q  <= sweep_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) life_q <= cfg_wdata_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    off_q   <= off_d;
    odata_q <= odata_d;
  end

endmodule

/* rtl/iprt_checker.sv */
// Port-level checker for the fragment table, bound to the top level.
module iprt_checker import iprt_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A real operation keeps the input closed on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.opcode != OpNone |=> !in_ready_o)
    else $error("input reopened during an operation");

  // Add answers are single and final
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == StAdded || out_data_o.status == StFull)
    |-> out_data_o.last)
    else $error("add result not final");

  // Only an added result carries an ident
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != StAdded |-> out_data_o.ident_out == '0)
    else $error("ident on non-add result");

  // Only emitted fragments carry offset, length and handle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != StFrag
    |-> out_data_o.byte_offset == '0 && out_data_o.payload_len == '0
        && out_data_o.handle_out == '0)
    else $error("fragment fields on status result");

endmodule

bind ipv4_fragment_reassembly_table iprt_checker u_iprt_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
  .out_valid_o, .out_ready_i, .out_data_o
);

/* bench/frag_table_checker.sv */
// Checker: watches the item and result transfers, predicts results and compares them.
module frag_table_checker import iprt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  input  logic      cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  output int        fail_count_o,
  output int        pending_o
);

  // Predicted copy of the descriptor table
  entry_t      tbl_q[$];
  logic [7:0]  life_sec;
  logic [31:0] sweep_time;
  out_item_t   expected_q[$];

  assign pending_o = expected_q.size();

  task automatic report_mismatch(input string what, input out_item_t got, input out_item_t want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    fail_count_o++;
  endtask

  function automatic out_item_t mk(input status_e st, input logic [15:0] id,
                                   input logic [15:0] off, input logic [15:0] len,
                                   input logic [7:0] h, input logic lst);
    out_item_t r;
    r.status = st; r.ident_out = id; r.byte_offset = off;
    r.payload_len = len; r.handle_out = h; r.last = lst;
    return r;
  endfunction

  // Work out the results one accepted item causes
  task automatic predict_item(input in_item_t it);
    entry_t e;
    logic [15:0] off;
    bit found;
    int i;
    int k;
    case (op_e'(it.opcode))
      OpAdd: begin
        if (sweep_time < it.now_seconds) begin
          sweep_time = it.now_seconds;
          i = 0;
          while (i < tbl_q.size()) begin
            if (tbl_q[i].expire <= it.now_seconds) tbl_q.delete(i);
            else i++;
          end
        end
        if (tbl_q.size() >= TableDepth) begin
          expected_q.push_back(mk(StFull, '0, '0, '0, '0, 1'b1));
        end else begin
          e.ident = it.ident; e.offset_units = it.offset_units;
          e.more = it.more_flag;
          e.payload_len = it.total_length - {10'd0, it.header_words, 2'b00};
          e.expire = it.now_seconds + {24'd0, life_sec};
          e.handle = it.buffer_handle;
          tbl_q.push_back(e);
          expected_q.push_back(mk(StAdded, it.ident, '0, '0, '0, 1'b1));
        end
      end
      OpCheck: begin
        off = '0; found = 1'b1;
        for (int p = 0; p < TableDepth && found; p++) begin
          found = 1'b0;
          foreach (tbl_q[j]) begin
            if (tbl_q[j].ident == it.ident && {tbl_q[j].offset_units, 3'b000} == off) begin
              found = 1'b1;
              off = off + tbl_q[j].payload_len;
              if (!tbl_q[j].more) begin
                expected_q.push_back(mk(StComplete, '0, '0, '0, '0, 1'b1));
                return;
              end
            end
          end
        end
        expected_q.push_back(mk(StIncomplete, '0, '0, '0, '0, 1'b1));
      end
      OpExtract: begin
        off = '0; found = 1'b1; k = 0;
        for (int p = 0; p <= TableDepth && found; p++) begin
          found = 1'b0;
          i = 0;
          while (i < tbl_q.size()) begin
            if (tbl_q[i].ident != it.ident || {tbl_q[i].offset_units, 3'b000} != off) begin
              i++;
            end else begin
              found = 1'b1;
              e = tbl_q[i];
              tbl_q.delete(i);
              if (k < TableDepth) begin
                expected_q.push_back(mk(StFrag, '0, off, e.payload_len, e.handle, !e.more));
                k++;
              end
              off = off + e.payload_len;
              if (!e.more) return;
            end
          end
        end
        expected_q.push_back(mk(StBroken, '0, '0, '0, '0, 1'b1));
      end
      default: ;
    endcase
  endtask

  // Track transfers on all channels
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      tbl_q.delete(); expected_q.delete();
      life_sec = LifetimeReset; sweep_time = '0; fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_data_i, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.status !== want.status) report_mismatch("status", out_data_i, want);
          if (out_data_i.ident_out !== want.ident_out) report_mismatch("ident", out_data_i, want);
          if (out_data_i.byte_offset !== want.byte_offset)
            report_mismatch("offset", out_data_i, want);
          if (out_data_i.payload_len !== want.payload_len)
            report_mismatch("length", out_data_i, want);
          if (out_data_i.handle_out !== want.handle_out)
            report_mismatch("handle", out_data_i, want);
          if (out_data_i.last !== want.last) report_mismatch("last", out_data_i, want);
        end
      end
      if (in_valid_i && in_ready_i) predict_item(in_data_i);
      if (cfg_we_i) life_sec = cfg_wdata_i;
    end
  end

endmodule

/* bench/tb_top.sv */
// Testbench top: stimulus, idling, configuration phases and verdict for the fragment table.
module tb_top;
  import iprt_pkg::*;

  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      in_valid = 0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_item_t out_data;
  logic      cfg_we = 0;
  logic [7:0] cfg_wdata = 0;
  int        fail_count;
  int        pending;

  int          idle_cycles;
  bit          no_idle = 0;
  bit          hold_off = 0;
  logic [31:0] clock_sec = 100;
  logic [15:0] id_pool[4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h00A5};

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  ipv4_fragment_reassembly_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  frag_table_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver: random stall bursts, or a long hold-off when asked
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (600) @(posedge clk_i);
        hold_off = 0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 6);
        repeat (n) @(posedge clk_i);
      end else begin
        out_ready <= 1;
        @(posedge clk_i);
      end
    end
  end

  // Watchdog on cycles without a transfer
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Valid stays up from one transfer to the next unless a random idle gap is inserted; drain() lowers it
  task automatic send_item(input in_item_t it);
    int n;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      n = $urandom_range(1, 6);
      repeat (n) @(posedge clk_i);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  function automatic in_item_t frag_item(input logic [15:0] id, input logic [12:0] offs,
                                         input logic mf, input logic [15:0] plen,
                                         input logic [31:0] now);
    in_item_t it;
    it.opcode = OpAdd; it.ident = id; it.offset_units = offs; it.more_flag = mf;
    it.header_words = 4'($urandom_range(0, 15));
    it.total_length = plen + {10'd0, it.header_words, 2'b00};
    it.buffer_handle = 8'($urandom); it.now_seconds = now;
    return it;
  endfunction

  function automatic in_item_t query_item(input op_e op, input logic [15:0] id);
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom}));
    it.opcode = op; it.ident = id;
    return it;
  endfunction

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  task automatic write_lifetime(input logic [7:0] v);
    drain();
    cfg_we <= 1; cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 0;
  endtask

  // A well-formed chain with random content, in shuffled order
  task automatic send_chain(input logic [15:0] id, input int nfrag);
    in_item_t parts[$];
    logic [15:0] off;
    logic [15:0] plen;
    int j;
    off = '0;
    for (int f = 0; f < nfrag; f++) begin
      plen = 16'(($urandom_range(1, 40)) * 8);
      parts.push_back(frag_item(id, off[15:3], f != nfrag - 1, plen, clock_sec));
      off = off + plen;
    end
    while (parts.size() > 0) begin
      j = $urandom_range(0, parts.size() - 1);
      send_item(parts[j]);
      parts.delete(j);
    end
  endtask

  initial begin
    in_item_t it;
    int sent;
    int r;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: field extremes, every opcode and the special cases
    send_item(query_item(OpCheck, 16'h0));
    send_item(query_item(OpExtract, 16'h0));
    send_item(frag_item(16'hFFFF, 13'h1FFF, 1'b1, 16'hFFFF, 32'hFFFF_FFF0));
    it = frag_item(16'h0001, 13'd0, 1'b1, 16'd0, 32'hFFFF_FFF0);
    it.total_length = 16'h0; it.header_words = 4'hF;
    send_item(it);
    send_item(frag_item(16'h0002, 13'd0, 1'b1, 16'd0, 32'hFFFF_FFF0));
    send_item(query_item(OpCheck, 16'h0002));
    send_item(query_item(OpExtract, 16'h0002));
    send_item(query_item(OpNone, 16'h0002));
    send_item(query_item(OpExtract, 16'hFFFF));
    send_item(frag_item(16'h0003, 13'd0, 1'b0, 16'd64, 32'hFFFF_FFF0));
    send_item(query_item(OpCheck, 16'h0003));
    send_item(query_item(OpExtract, 16'h0003));
    // Wrapping expiry, then an add at time zero does not sweep
    send_item(frag_item(16'h0004, 13'd0, 1'b0, 16'd8, 32'hFFFF_FFFF));
    send_item(frag_item(16'h0005, 13'd0, 1'b0, 16'd8, 32'h0));
    write_lifetime(8'd0);
    send_item(frag_item(16'h0006, 13'd0, 1'b0, 16'd8, 32'd5));
    write_lifetime(8'd255);
    // Fill the table past full while the receiver holds off
    hold_off = 1;
    for (int f = 0; f < 18; f++) send_item(frag_item(16'h0007, 13'(f), 1'b1, 16'd8, 32'd5));
    drain();
    send_item(query_item(OpCheck, 16'h0007));
    send_item(query_item(OpExtract, 16'h0007));
    // One more add, earlier than the last sweep time, so no sweep
    send_item(frag_item(16'h0008, 13'd0, 1'b0, 16'd8, 32'd100));
    drain();

    // Random part: mostly chains, some noise
    sent = 0;
    while (sent < 330) begin
      if (sent == 120) write_lifetime(8'd3);
      if (sent == 220) write_lifetime(LifetimeReset);
      if (sent > 290) no_idle = 1;
      if ($urandom_range(0, 7) == 0) clock_sec = clock_sec + $urandom_range(1, 4);
      r = $urandom_range(0, 9);
      if (r < 5) begin
        r = $urandom_range(1, 4);
        send_chain(id_pool[$urandom_range(0, 3)], r);
        sent += r;
        send_item(query_item($urandom_range(0, 1) ? OpCheck : OpExtract,
                             id_pool[$urandom_range(0, 3)]));
      end else if (r < 7) begin
        send_item(frag_item(id_pool[$urandom_range(0, 3)], $urandom_range(0, 3) == 0 ?
                            13'($urandom) : 13'($urandom_range(0, 40)),
                            1'($urandom_range(0, 1)), 16'($urandom), clock_sec));
      end else if (r < 9) begin
        send_item(query_item($urandom_range(0, 1) ? OpCheck : OpExtract,
                             id_pool[$urandom_range(0, 3)]));
      end else begin
        it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom}));
        send_item(it);
      end
      sent++;
    end

    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
